@@ sv/cts_pkg.sv @@
// Shared types and constants for the four-voice chiptune synthesizer.
package cts_pkg;

    localparam int MAX_VOICES = 4;
    localparam int PHASE_W    = 16;
    localparam int VOL_W      = 8;
    localparam int WAVE_W     = 6;
    localparam int PROD_W     = 14;
    localparam int SAMPLE_W   = 16;
    localparam int NOISE_W    = 32;

    localparam logic [PHASE_W-1:0]  WIDTH_RESET   = 16'h8000;
    localparam logic [SAMPLE_W-1:0] SAMPLE_OFFSET = 16'h8000;
    localparam logic [NOISE_W-1:0]  NOISE_RESET   = 32'h0000_0001;

    typedef enum logic [0:0] {
        KIND_TICK  = 1'b0,
        KIND_WRITE = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        SHAPE_TRIANGLE = 2'd0,
        SHAPE_SAWTOOTH = 2'd1,
        SHAPE_PULSE    = 2'd2,
        SHAPE_NOISE    = 2'd3
    } shape_t;

    typedef struct packed {
        kind_t              kind;
        logic [1:0]         voice;
        logic [PHASE_W-1:0] tone_step;
        logic [PHASE_W-1:0] pulse_width;
        logic [VOL_W-1:0]   voice_volume;
        shape_t             wave_shape;
    } item_t;

    typedef struct packed {
        logic advance;
        logic fire;
    } stage_ctl_t;

endpackage

@@ sv/cts_if.sv @@
// Request and sample channel interfaces with valid/ready handshake.
interface cts_req_if
    import cts_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [0:0]         kind;
    logic [1:0]         voice;
    logic [PHASE_W-1:0] tone_step;
    logic [PHASE_W-1:0] pulse_width;
    logic [VOL_W-1:0]   voice_volume;
    logic [1:0]         wave_shape;

    modport source (
        output valid, kind, voice, tone_step, pulse_width, voice_volume, wave_shape,
        input  ready
    );
    modport sink (
        input  valid, kind, voice, tone_step, pulse_width, voice_volume, wave_shape,
        output ready
    );
endinterface

interface cts_sample_if
    import cts_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (
        output valid, sample,
        input  ready
    );
    modport sink (
        input  valid, sample,
        output ready
    );
endinterface

@@ sv/cts_voice_bank.sv @@
// Voice state, noise generator, wave shaping and per-voice volume products.
module cts_voice_bank
    import cts_pkg::*;
#(
    parameter int VOICES = 4
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  stage_ctl_t               ctl,
    input  item_t                    item,
    output logic                     tick_valid,
    output logic signed [PROD_W-1:0] prod [VOICES]
);

    logic [NOISE_W-1:0] noise_reg;
    logic [NOISE_W-1:0] noise_next;
    logic               tick_reg;
    logic               is_tick;
    logic               is_write;

    assign is_tick    = ctl.fire && (item.kind == KIND_TICK);
    assign is_write   = ctl.fire && (item.kind == KIND_WRITE);
    assign noise_next = {noise_reg[NOISE_W-2:0],
                         noise_reg[31] ^ noise_reg[24] ^ noise_reg[9] ^ noise_reg[6]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_reg <= NOISE_RESET;
            tick_reg  <= 1'b0;
        end
        else
        begin
            if (is_tick)
            begin
                noise_reg <= noise_next;
            end
            if (ctl.advance)
            begin
                tick_reg <= is_tick;
            end
        end
    end

    assign tick_valid = tick_reg;

    for (genvar v = 0; v < VOICES; v++)
    begin : g_voice
        logic [PHASE_W-1:0]      phase_reg;
        logic [PHASE_W-1:0]      step_reg;
        logic [PHASE_W-1:0]      width_reg;
        logic [VOL_W-1:0]        volume_reg;
        shape_t                  shape_reg;
        logic signed [WAVE_W-1:0] wave;
        logic signed [PROD_W-1:0] prod_reg;
        logic                    hit;

        assign hit = is_write && (item.voice == 2'(v));

        always_comb
        begin
            unique case (shape_reg)
                SHAPE_TRIANGLE:
                begin
                    if (!phase_reg[15])
                        wave = {~phase_reg[14], phase_reg[13:9]};
                    else
                        wave = {phase_reg[14], ~phase_reg[13:9]};
                end
                SHAPE_SAWTOOTH: wave = {~phase_reg[15], phase_reg[14:10]};
                SHAPE_PULSE:    wave = (phase_reg > width_reg) ? 6'sh20 : 6'sh1f;
                SHAPE_NOISE:    wave = {~noise_next[5], noise_next[4:0]};
                default:        wave = '0;
            endcase
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                phase_reg  <= '0;
                step_reg   <= '0;
                width_reg  <= WIDTH_RESET;
                volume_reg <= '0;
                shape_reg  <= SHAPE_TRIANGLE;
            end
            else if (hit)
            begin
                step_reg   <= item.tone_step;
                width_reg  <= item.pulse_width;
                volume_reg <= item.voice_volume;
                shape_reg  <= item.wave_shape;
            end
            else if (is_tick)
            begin
                phase_reg <= phase_reg + step_reg;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.advance)
            begin
                prod_reg <= PROD_W'(wave) * $signed({{(PROD_W-VOL_W){1'b0}}, volume_reg});
            end
        end

        assign prod[v] = prod_reg;
    end

endmodule

@@ sv/cts_mixer.sv @@
// Sum of voice products, offset to unsigned, held in the result register.
module cts_mixer
    import cts_pkg::*;
#(
    parameter int VOICES = 4
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     advance,
    input  logic                     tick_valid,
    input  logic signed [PROD_W-1:0] prod [VOICES],
    output logic                     valid,
    output logic [SAMPLE_W-1:0]      sample
);

    logic signed [SAMPLE_W-1:0] sum;
    logic                       valid_reg;
    logic [SAMPLE_W-1:0]        sample_reg;

    always_comb
    begin
        sum = '0;
        for (int v = 0; v < VOICES; v++)
        begin
            sum = sum + SAMPLE_W'(prod[v]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= tick_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            sample_reg <= sum ^ SAMPLE_OFFSET;
    end

    assign valid  = valid_reg;
    assign sample = sample_reg;

endmodule

@@ sv/four_voice_chiptune_synth.sv @@
// Top level of the four-voice chiptune synthesizer.
//
//  channel | dir | payload
//  --------+-----+------------------------------------------------------------
//  cmd     | in  | kind, voice, tone_step, pulse_width, voice_volume, wave_shape
//  audio   | out | sample
//
// One request per cycle unless the pipeline stalls; a tick's sample passes the request
// register, product register and result register before it is valid on audio.
// A write request produces no sample; the pipeline runs as one stalled unit.
// When the result register is full and audio.ready is low, cmd.ready drops.
// Reset loads default voice settings and the noise seed at once.
module four_voice_chiptune_synth
    import cts_pkg::*;
#(
    parameter int VOICES = 4
) (
    input logic  clk,
    input logic  rst_n,
    cts_req_if.sink      cmd,
    cts_sample_if.source audio
);

    logic                     req_valid_reg;
    item_t                    item_reg;
    logic                     advance;
    logic                     tick_valid;
    logic                     out_valid;
    stage_ctl_t               ctl;
    logic signed [PROD_W-1:0] prod [VOICES];

    assign advance     = !out_valid || audio.ready;
    assign cmd.ready   = advance;
    assign ctl.advance = advance;
    assign ctl.fire    = advance && req_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_valid_reg <= 1'b0;
        else if (advance)
            req_valid_reg <= cmd.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            item_reg.kind         <= kind_t'(cmd.kind);
            item_reg.voice        <= cmd.voice;
            item_reg.tone_step    <= cmd.tone_step;
            item_reg.pulse_width  <= cmd.pulse_width;
            item_reg.voice_volume <= cmd.voice_volume;
            item_reg.wave_shape   <= shape_t'(cmd.wave_shape);
        end
    end

    cts_voice_bank #(
        .VOICES(VOICES)
    ) u_voice_bank (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .item       (item_reg),
        .tick_valid (tick_valid),
        .prod       (prod)
    );

    cts_mixer #(
        .VOICES(VOICES)
    ) u_mixer (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .tick_valid (tick_valid),
        .prod       (prod),
        .valid      (out_valid),
        .sample     (audio.sample)
    );

    assign audio.valid = out_valid;

endmodule
